// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every rising edge, reset included
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/pit_pkg.sv =====
// ---------------------------------------------------------------------------
// pit_pkg
// Widths, payload types and stage records of the point-in-triangle test.
// ---------------------------------------------------------------------------
package pit_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int DOT_W       = PROD_W + 2;
  localparam int FULL_W      = 2 * DOT_W;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DOT_W-1:0]       dot_t;
  typedef logic signed [FULL_W-1:0]      full_t;

  typedef struct packed {
    coord_t vert_a_x;
    coord_t vert_a_y;
    coord_t vert_a_z;
    coord_t vert_b_x;
    coord_t vert_b_y;
    coord_t vert_b_z;
    coord_t vert_c_x;
    coord_t vert_c_y;
    coord_t vert_c_z;
    coord_t query_x;
    coord_t query_y;
    coord_t query_z;
  } pit_req_t;

  typedef struct packed {
    logic inside_res;
    logic degenerate;
  } pit_res_t;

  typedef struct packed {
    dot_t d00;
    dot_t d01;
    dot_t d02;
    dot_t d11;
    dot_t d12;
  } pit_dots_t;

  typedef struct packed {
    full_t den_a;
    full_t den_b;
    full_t un_a;
    full_t un_b;
    full_t vn_a;
    full_t vn_b;
  } pit_prods_t;

endpackage

// ===== hw/rtl/point_in_triangle_test.sv =====
// ---------------------------------------------------------------------------
// point_in_triangle_test
// Exact barycentric point-in-triangle test on signed integer 3D coordinates.
// ---------------------------------------------------------------------------
// Usage:
//   A request on req (req_valid / req_stall) carries triangle vertices a, b, c
//   and a query point. One response on res (res_valid / res_stall) follows
//   for every request, in order: inside_res is set when the point, projected
//   onto the triangle's plane, lies within or on the triangle; degenerate is
//   set for a zero-area triangle, which never reports inside.
//   A request passes through 7 register stages, the first loaded at the
//   accepting edge: 3 stages of edge vectors and dot products, 2 stages of
//   split wide multiplies, and 2 stages of numerator differences and sign
//   tests ending in the output register. Throughput is one request per cycle
//   while res_stall is low.
//   Synchronous reset empties every stage; no request is held across it.
//   While res_stall is high the output register holds, and stages upstream
//   keep filling empty slots, so req_stall rises only once all 7 stages are
//   occupied.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module point_in_triangle_test (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  pit_pkg::pit_req_t  req,
  output logic               res_valid,
  input  logic               res_stall,
  output pit_pkg::pit_res_t  res
);
  import pit_pkg::*;

  logic       req_ready;
  logic       dots_valid;
  logic       dots_ready;
  pit_dots_t  dots;
  logic       prods_valid;
  logic       prods_ready;
  pit_prods_t prods;

  pit_dots u_dots (
    .clk      (clk),
    .rst      (rst),
    .up_valid (req_valid),
    .up_ready (req_ready),
    .up_req   (req),
    .dn_valid (dots_valid),
    .dn_ready (dots_ready),
    .dn_dots  (dots)
  );

  pit_wmul u_wmul (
    .clk      (clk),
    .rst      (rst),
    .up_valid (dots_valid),
    .up_ready (dots_ready),
    .up_dots  (dots),
    .dn_valid (prods_valid),
    .dn_ready (prods_ready),
    .dn_prods (prods)
  );

  pit_decide u_decide (
    .clk      (clk),
    .rst      (rst),
    .up_valid (prods_valid),
    .up_ready (prods_ready),
    .up_prods (prods),
    .dn_valid (res_valid),
    .dn_ready (!res_stall),
    .dn_res   (res)
  );

  assign req_stall = !req_ready;

  `ASSERT_CLK_ALWAYS(a_reset_empties, clk, rst |=> !res_valid, "response valid after reset")
  `ASSERT_CLK(a_empty_out_no_stall, clk, rst, !res_valid |-> !req_stall, "stall while empty")
  `ASSERT_CLK(a_degen_not_inside, clk, rst, res_valid |-> !(res.inside_res && res.degenerate), "degenerate inside")

endmodule

// ===== hw/rtl/pit_dots.sv =====
// ---------------------------------------------------------------------------
// pit_dots
// Edge vectors, coordinate products and the five dot products (3 stages).
// ---------------------------------------------------------------------------
module pit_dots (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  pit_pkg::pit_req_t    up_req,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output pit_pkg::pit_dots_t   dn_dots
);
  import pit_pkg::*;

  localparam int NSTG = 3;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  logic [NSTG-1:0] vld;
  logic [NSTG:0]   rdy;

  coord_t ca[3];
  coord_t cb[3];
  coord_t cc[3];
  coord_t cp[3];

  diff_t e0[3];
  diff_t e1[3];
  diff_t ew[3];
  prod_t pr[5][3];
  dot_t  dot_r[5];

  always_comb begin
    ca[0] = up_req.vert_a_x;  ca[1] = up_req.vert_a_y;  ca[2] = up_req.vert_a_z;
    cb[0] = up_req.vert_b_x;  cb[1] = up_req.vert_b_y;  cb[2] = up_req.vert_b_z;
    cc[0] = up_req.vert_c_x;  cc[1] = up_req.vert_c_y;  cc[2] = up_req.vert_c_z;
    cp[0] = up_req.query_x;   cp[1] = up_req.query_y;   cp[2] = up_req.query_z;
  end

  always_comb begin
    rdy[NSTG] = dn_ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= up_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int k = 0; k < 3; k++) begin
        e0[k] <= diff_t'({cc[k][COORD_WIDTH-1], cc[k]}) - diff_t'({ca[k][COORD_WIDTH-1], ca[k]});
        e1[k] <= diff_t'({cb[k][COORD_WIDTH-1], cb[k]}) - diff_t'({ca[k][COORD_WIDTH-1], ca[k]});
        ew[k] <= diff_t'({cp[k][COORD_WIDTH-1], cp[k]}) - diff_t'({ca[k][COORD_WIDTH-1], ca[k]});
      end
    end
    if (rdy[1]) begin
      for (int k = 0; k < 3; k++) begin
        pr[0][k] <= prod_t'(e0[k]) * prod_t'(e0[k]);
        pr[1][k] <= prod_t'(e0[k]) * prod_t'(e1[k]);
        pr[2][k] <= prod_t'(e0[k]) * prod_t'(ew[k]);
        pr[3][k] <= prod_t'(e1[k]) * prod_t'(e1[k]);
        pr[4][k] <= prod_t'(e1[k]) * prod_t'(ew[k]);
      end
    end
    if (rdy[2]) begin
      for (int j = 0; j < 5; j++) begin
        dot_r[j] <= dot_t'(pr[j][0]) + dot_t'(pr[j][1]) + dot_t'(pr[j][2]);
      end
    end
  end

  assign up_ready    = rdy[0];
  assign dn_valid    = vld[NSTG-1];
  assign dn_dots.d00 = dot_r[0];
  assign dn_dots.d01 = dot_r[1];
  assign dn_dots.d02 = dot_r[2];
  assign dn_dots.d11 = dot_r[3];
  assign dn_dots.d12 = dot_r[4];

endmodule

// ===== hw/rtl/pit_wmul.sv =====
// ---------------------------------------------------------------------------
// pit_wmul
// Six wide dot-product multiplies as split partial products (2 stages).
// ---------------------------------------------------------------------------
module pit_wmul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  pit_pkg::pit_dots_t   up_dots,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output pit_pkg::pit_prods_t  dn_prods
);
  import pit_pkg::*;

  localparam int NSTG   = 2;
  localparam int NMUL   = 6;
  localparam int HALF_W = (DOT_W + 1) / 2;
  localparam int HI_W   = DOT_W - HALF_W;
  localparam int LL_W   = 2 * HALF_W;
  localparam int MID_W  = HALF_W + 1 + HI_W;
  localparam int HH_W   = 2 * HI_W;

  typedef logic [LL_W-1:0]         ll_t;
  typedef logic signed [MID_W-1:0] mid_t;
  typedef logic signed [HH_W-1:0]  hh_t;

  logic [NSTG-1:0] vld;
  logic [NSTG:0]   rdy;

  dot_t  op_a[NMUL];
  dot_t  op_b[NMUL];
  ll_t   ll[NMUL];
  mid_t  lh[NMUL];
  mid_t  hl[NMUL];
  hh_t   hh[NMUL];
  full_t prod[NMUL];

  always_comb begin
    op_a[0] = up_dots.d00;  op_b[0] = up_dots.d11;
    op_a[1] = up_dots.d01;  op_b[1] = up_dots.d01;
    op_a[2] = up_dots.d11;  op_b[2] = up_dots.d02;
    op_a[3] = up_dots.d01;  op_b[3] = up_dots.d12;
    op_a[4] = up_dots.d00;  op_b[4] = up_dots.d12;
    op_a[5] = up_dots.d01;  op_b[5] = up_dots.d02;
  end

  always_comb begin
    rdy[NSTG] = dn_ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= up_valid;
      if (rdy[1]) vld[1] <= vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int i = 0; i < NMUL; i++) begin
        ll[i] <= ll_t'(op_a[i][HALF_W-1:0]) * ll_t'(op_b[i][HALF_W-1:0]);
        lh[i] <= mid_t'($signed({1'b0, op_a[i][HALF_W-1:0]}))
               * mid_t'($signed(op_b[i][DOT_W-1:HALF_W]));
        hl[i] <= mid_t'($signed(op_a[i][DOT_W-1:HALF_W]))
               * mid_t'($signed({1'b0, op_b[i][HALF_W-1:0]}));
        hh[i] <= hh_t'($signed(op_a[i][DOT_W-1:HALF_W]))
               * hh_t'($signed(op_b[i][DOT_W-1:HALF_W]));
      end
    end
    if (rdy[1]) begin
      for (int i = 0; i < NMUL; i++) begin
        prod[i] <= full_t'(ll[i])
                 + (full_t'(lh[i]) <<< HALF_W)
                 + (full_t'(hl[i]) <<< HALF_W)
                 + (full_t'(hh[i]) <<< (2 * HALF_W));
      end
    end
  end

  assign up_ready       = rdy[0];
  assign dn_valid       = vld[NSTG-1];
  assign dn_prods.den_a = prod[0];
  assign dn_prods.den_b = prod[1];
  assign dn_prods.un_a  = prod[2];
  assign dn_prods.un_b  = prod[3];
  assign dn_prods.vn_a  = prod[4];
  assign dn_prods.vn_b  = prod[5];

endmodule

// ===== hw/rtl/pit_decide.sv =====
// ---------------------------------------------------------------------------
// pit_decide
// Numerators, denominator and the final sign tests; holds the result register.
// ---------------------------------------------------------------------------
module pit_decide (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  pit_pkg::pit_prods_t  up_prods,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output pit_pkg::pit_res_t    dn_res
);
  import pit_pkg::*;

  localparam int NSTG  = 2;
  localparam int FIN_W = FULL_W + 3;

  typedef logic signed [FIN_W-1:0] fin_t;

  logic [NSTG-1:0] vld;
  logic [NSTG:0]   rdy;

  fin_t     den;
  fin_t     un;
  fin_t     vn;
  fin_t     slack;
  pit_res_t res_r;

  always_comb begin
    rdy[NSTG] = dn_ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= up_valid;
      if (rdy[1]) vld[1] <= vld[0];
    end
  end

  assign slack = den - (un + vn);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      den <= fin_t'(up_prods.den_a) - fin_t'(up_prods.den_b);
      un  <= fin_t'(up_prods.un_a) - fin_t'(up_prods.un_b);
      vn  <= fin_t'(up_prods.vn_a) - fin_t'(up_prods.vn_b);
    end
    if (rdy[1]) begin
      res_r.degenerate <= (den == '0);
      res_r.inside_res <= (den != '0) && !den[FIN_W-1] && !un[FIN_W-1]
                          && !vn[FIN_W-1] && !slack[FIN_W-1];
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = vld[NSTG-1];
  assign dn_res   = res_r;

endmodule
